// ===== sv/load_cell_weigh_and_tare_core_defines.svh =====
// Assertion macros shared by the weigh and tare RTL.
`ifndef LOAD_CELL_WEIGH_AND_TARE_CORE_DEFINES_SVH
`define LOAD_CELL_WEIGH_AND_TARE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LCWT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LCWT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lcwt_pkg.sv =====
// Shared types, codes and constants of the weigh and tare core.
`default_nettype none
package lcwt_pkg;

  // Default sizes
  localparam int DEF_WINDOW_DEPTH = 12;
  localparam int DEF_SAMPLE_BITS  = 24;

  // Fixed field widths
  localparam int ACC_BITS    = 28;
  localparam int WEIGHT_W    = 16;
  localparam int DIVISOR_W   = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int DEPTH_CFG_W = 4;
  localparam int REFRESH_W   = 8;

  // Register reset values
  localparam logic [DEPTH_CFG_W-1:0] DEF_AVG_DEPTH = 4'd3;
  localparam logic [WEIGHT_W-1:0]    DEF_WARN      = 16'd5000;
  localparam logic [DIVISOR_W-1:0]   DEF_SCALE     = 16'd395;
  localparam logic [REFRESH_W-1:0]   DEF_REFRESH   = 8'd2;

  // Sample tags
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_TARE    = 1'b1;

  typedef enum logic [1:0] {
    CFG_AVG_DEPTH  = 2'd0,
    CFG_WARN_LIMIT = 2'd1,
    CFG_SCALE_DIV  = 2'd2,
    CFG_REFRESH    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_POS      = 2'd0,
    KIND_OVER     = 2'd1,
    KIND_NEG      = 2'd2,
    KIND_NEG_ZERO = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TARE_WR,
    ST_TARE_GO,
    ST_TARE_WAIT,
    ST_MEAS_WR,
    ST_SUM,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_NET_GO,
    ST_NET_WAIT,
    ST_RESULT
  } state_t;

  // Window port strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } win_ctl_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ===== sv/lcwt_window.sv =====
// Sample window memory with per-entry valid bits that read as zero.
`default_nettype none
module lcwt_window #(
  parameter int WINDOW_DEPTH = lcwt_pkg::DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = lcwt_pkg::DEF_SAMPLE_BITS,
  parameter int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lcwt_pkg::win_ctl_t     ctl,
  input  wire logic [IDX_W-1:0]       wr_addr,
  input  wire logic [SAMPLE_BITS-1:0] wr_data,
  input  wire logic [IDX_W-1:0]       rd_addr,
  output logic [SAMPLE_BITS-1:0]      rd_data
);
  import lcwt_pkg::*;
  `include "load_cell_weigh_and_tare_core_defines.svh"

  logic [SAMPLE_BITS-1:0]  mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] valid_r;
  logic [SAMPLE_BITS-1:0]  rd_raw_r;
  logic                    rd_hit_r;

  // Write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Mark written entries; reset empties the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_raw_r <= mem[rd_addr];
      rd_hit_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_hit_r ? rd_raw_r : '0;

  `LCWT_ASSERT_IMP(a_wr_in_range, ctl.wr_en, int'(wr_addr) < WINDOW_DEPTH, "window write out of range")

endmodule
`default_nettype wire

// ===== sv/lcwt_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lcwt_divider #(
  parameter int DIVN_W = 28,
  parameter int DIVS_W = lcwt_pkg::DIVISOR_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIVN_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output logic [DIVN_W-1:0]      quotient,
  output lcwt_pkg::div_stat_t    stat
);
  import lcwt_pkg::*;
  `include "load_cell_weigh_and_tare_core_defines.svh"

  localparam int CNT_W = $clog2(DIVN_W + 1);

  logic [DIVN_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [DIVS_W:0]   rem_sh;
  logic [DIVS_W:0]   rem_sub;
  logic              ge;

  // One shift-compare-subtract step
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIVN_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
    rem_nxt = ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
    quo_nxt = {quo_r[DIVN_W-2:0], ge};
  end

  // Operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVN_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  `LCWT_ASSERT_IMP(a_no_restart, start, !busy_r, "divider started while busy")
  `LCWT_ASSERT_NXT(a_done_pulse, done_r, !done_r && !busy_r, "divider done not a single pulse")

endmodule
`default_nettype wire

// ===== sv/load_cell_weigh_and_tare_core.sv =====
// Top level: registers, sequencer and result register of the weigh and tare core.
//
//  channel | direction | handshake           | word
//  in_     | input     | in_valid/in_ready   | command, sample
//  out_    | output    | out_valid/out_ready | result_kind, weight_magnitude, alarm, average_value
//  cfg_    | input     | cfg_we              | cfg_index, cfg_data
//
// One word at a time; in_ready is high only while the sequencer is idle and out of reset.
// A measurement either gives no result or runs the window sum and two divisions.
// The shared divider has a dividend width of 28 bits by default.
// A tare word is written to the window; the last of a tare set also runs the divider once.
// The tare, average and net divisions share the one divider; the window sum uses one adder.
// A finished result waits in the output register; the next word is taken meanwhile.
// Reset is synchronous; the window valid bits clear at once, no clearing pass.
`default_nettype none
module load_cell_weigh_and_tare_core #(
  parameter int WINDOW_DEPTH = lcwt_pkg::DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = lcwt_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_command,
  input  wire logic [SAMPLE_BITS-1:0]        in_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output lcwt_pkg::kind_t                    out_result_kind,
  output logic [lcwt_pkg::WEIGHT_W-1:0]      out_weight_magnitude,
  output logic                               out_alarm,
  output logic [SAMPLE_BITS-1:0]             out_average_value,
  input  wire logic                          cfg_we,
  input  wire lcwt_pkg::cfg_idx_t            cfg_index,
  input  wire logic [lcwt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lcwt_pkg::*;
  `include "load_cell_weigh_and_tare_core_defines.svh"

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int DIVN_W = (SUM_W > ACC_BITS) ? SUM_W : ACC_BITS;

  // Configuration registers
  logic [DEPTH_CFG_W-1:0] depth_cfg_r;
  logic [WEIGHT_W-1:0]    warn_r;
  logic [DIVISOR_W-1:0]   scale_r;
  logic [REFRESH_W-1:0]   refresh_r;

  // Sequencer and state
  state_t                 state_r, state_nxt;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic [IDX_W-1:0]       ring_pos_r, tare_pos_r;
  logic [ACC_BITS-1:0]    acc_r;
  logic [SAMPLE_BITS-1:0] tare_r;
  logic [REFRESH_W-1:0]   refresh_cnt_r;
  logic                   alarm_r;
  logic [CNT_W-1:0]       sum_cnt_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SAMPLE_BITS-1:0] avg_r;
  logic                   neg_r;
  logic [WEIGHT_W-1:0]    mag_r;

  // Output register
  logic                   out_valid_r;
  kind_t                  kind_r;
  logic [WEIGHT_W-1:0]    weight_r;
  logic                   alarm_out_r;
  logic [SAMPLE_BITS-1:0] avg_out_r;

  // Derived values
  logic [CNT_W-1:0]       depth;
  logic [CNT_W-1:0]       ring_inc, tare_inc;
  logic [REFRESH_W-1:0]   refresh_inc;
  logic                   tare_last, no_result, sum_last, res_fire, over;
  logic [SAMPLE_BITS-1:0] net;
  logic                   net_neg;
  kind_t                  kind_nxt;

  // Shared unit hookup
  win_ctl_t               win_ctl;
  logic [IDX_W-1:0]       win_wr_addr, win_rd_addr;
  logic [SAMPLE_BITS-1:0] win_rd_data;
  logic                   div_start;
  logic [DIVN_W-1:0]      div_dividend, div_quotient;
  logic [DIVISOR_W-1:0]   div_divisor;
  div_stat_t              div_stat;

  lcwt_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .IDX_W        (IDX_W)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .wr_addr (win_wr_addr),
    .wr_data (smp_r),
    .rd_addr (win_rd_addr),
    .rd_data (win_rd_data)
  );

  lcwt_divider #(
    .DIVN_W (DIVN_W),
    .DIVS_W (DIVISOR_W)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  // Effective depth: zero acts as one, clamp to the window size
  always_comb begin
    if (depth_cfg_r == '0) begin
      depth = CNT_W'(1);
    end else if (int'(depth_cfg_r) > WINDOW_DEPTH) begin
      depth = CNT_W'(WINDOW_DEPTH);
    end else begin
      depth = CNT_W'(depth_cfg_r);
    end
  end

  // Position and counter arithmetic
  always_comb begin
    ring_inc    = CNT_W'(ring_pos_r) + 1'b1;
    tare_inc    = CNT_W'(tare_pos_r) + 1'b1;
    refresh_inc = refresh_cnt_r + 1'b1;
    tare_last   = tare_inc >= depth;
    no_result   = refresh_inc < refresh_r;
    sum_last    = sum_cnt_r == depth;
    res_fire    = !out_valid_r || out_ready;
    net_neg     = avg_r < tare_r;
    net         = net_neg ? (tare_r - avg_r) : (avg_r - tare_r);
    over        = mag_r > warn_r;
    if (neg_r) begin
      kind_nxt = (mag_r != '0) ? KIND_NEG : KIND_NEG_ZERO;
    end else begin
      kind_nxt = over ? KIND_OVER : KIND_POS;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = (in_command == CMD_TARE) ? ST_TARE_WR : ST_MEAS_WR;
      ST_TARE_WR:   state_nxt = tare_last ? ST_TARE_GO : ST_IDLE;
      ST_TARE_GO:   state_nxt = ST_TARE_WAIT;
      ST_TARE_WAIT: if (div_stat.done) state_nxt = ST_IDLE;
      ST_MEAS_WR:   state_nxt = no_result ? ST_IDLE : ST_SUM;
      ST_SUM:       if (sum_last) state_nxt = ST_AVG_GO;
      ST_AVG_GO:    state_nxt = ST_AVG_WAIT;
      ST_AVG_WAIT:  if (div_stat.done) state_nxt = ST_NET_GO;
      ST_NET_GO:    state_nxt = ST_NET_WAIT;
      ST_NET_WAIT:  if (div_stat.done) state_nxt = ST_RESULT;
      ST_RESULT:    if (res_fire) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready      = 1'b0;
    win_ctl.wr_en = 1'b0;
    win_ctl.rd_en = 1'b0;
    div_start     = 1'b0;
    win_wr_addr   = ring_pos_r;
    win_rd_addr   = IDX_W'(sum_cnt_r);
    div_dividend  = DIVN_W'(sum_r);
    div_divisor   = DIVISOR_W'(depth);
    unique case (state_r)
      ST_IDLE:    in_ready = rst_n;
      ST_TARE_WR: begin
        win_ctl.wr_en = 1'b1;
        win_wr_addr   = tare_pos_r;
      end
      ST_TARE_GO: begin
        div_start    = 1'b1;
        div_dividend = DIVN_W'(acc_r);
      end
      ST_MEAS_WR: win_ctl.wr_en = 1'b1;
      ST_SUM:     win_ctl.rd_en = sum_cnt_r < depth;
      ST_AVG_GO:  div_start = 1'b1;
      ST_NET_GO: begin
        div_start    = 1'b1;
        div_dividend = DIVN_W'(net);
        div_divisor  = (scale_r == '0) ? DIVISOR_W'(1) : scale_r;
      end
      ST_TARE_WAIT, ST_AVG_WAIT, ST_NET_WAIT, ST_RESULT: ;
      default: ;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_cfg_r <= DEF_AVG_DEPTH;
      warn_r      <= DEF_WARN;
      scale_r     <= DEF_SCALE;
      refresh_r   <= DEF_REFRESH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AVG_DEPTH:  depth_cfg_r <= cfg_data[DEPTH_CFG_W-1:0];
        CFG_WARN_LIMIT: warn_r      <= cfg_data[WEIGHT_W-1:0];
        CFG_SCALE_DIV:  scale_r     <= cfg_data[DIVISOR_W-1:0];
        CFG_REFRESH:    refresh_r   <= cfg_data[REFRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state: positions, counts, tare, alarm, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ring_pos_r    <= '0;
      tare_pos_r    <= '0;
      acc_r         <= '0;
      tare_r        <= '0;
      refresh_cnt_r <= '0;
      alarm_r       <= 1'b0;
      sum_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_TARE_WR: begin
          acc_r      <= acc_r + ACC_BITS'(smp_r);
          tare_pos_r <= tare_last ? '0 : IDX_W'(tare_inc);
        end
        ST_TARE_GO: acc_r <= '0;
        ST_TARE_WAIT: begin
          if (div_stat.done) begin
            tare_r <= (|div_quotient[DIVN_W-1:SAMPLE_BITS]) ? '1
                                                             : div_quotient[SAMPLE_BITS-1:0];
          end
        end
        ST_MEAS_WR: begin
          ring_pos_r    <= (ring_inc >= depth) ? '0 : IDX_W'(ring_inc);
          refresh_cnt_r <= no_result ? refresh_inc : '0;
          sum_cnt_r     <= '0;
        end
        ST_SUM:     if (!sum_last) sum_cnt_r <= sum_cnt_r + 1'b1;
        ST_RESULT:  if (res_fire && !neg_r) alarm_r <= over;
        ST_IDLE, ST_AVG_GO, ST_AVG_WAIT, ST_NET_GO, ST_NET_WAIT: ;
        default: ;
      endcase
      // Hold the result until taken
      if (state_r == ST_RESULT && res_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      smp_r <= in_sample;
    end
    if (state_r == ST_MEAS_WR) begin
      sum_r <= '0;
    end else if (state_r == ST_SUM && sum_cnt_r != '0) begin
      sum_r <= sum_r + SUM_W'(win_rd_data);
    end
    if (state_r == ST_AVG_WAIT && div_stat.done) begin
      avg_r <= div_quotient[SAMPLE_BITS-1:0];
    end
    if (state_r == ST_NET_GO) begin
      neg_r <= net_neg;
    end
    if (state_r == ST_NET_WAIT && div_stat.done) begin
      mag_r <= (|div_quotient[DIVN_W-1:WEIGHT_W]) ? '1 : div_quotient[WEIGHT_W-1:0];
    end
    if (state_r == ST_RESULT && res_fire) begin
      kind_r      <= kind_nxt;
      weight_r    <= mag_r;
      alarm_out_r <= neg_r ? alarm_r : over;
      avg_out_r   <= avg_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_result_kind      = kind_r;
  assign out_weight_magnitude = weight_r;
  assign out_alarm            = alarm_out_r;
  assign out_average_value    = avg_out_r;

  `LCWT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready held after accept")
  `LCWT_ASSERT_IMP(a_result_source, $rose(out_valid_r), $past(state_r == ST_RESULT), "result without sequence")
  `LCWT_ASSERT_IMP(a_over_alarm, out_valid_r && (kind_r == KIND_OVER), alarm_out_r, "overweight without alarm")

endmodule
`default_nettype wire
